FILE: rtl/i2cbr_pkg.sv
// ----------------------------------------------------------------------------
// i2cbr_pkg
// Shared types and constants of the I2C bus-clear recovery sequencer.
// ----------------------------------------------------------------------------
package i2cbr_pkg;

  localparam int TIMER_BITS_DEFAULT = 24;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_INIT_WAIT   = 3'd0;
  localparam logic [2:0] REG_HALF_PERIOD = 3'd1;
  localparam logic [2:0] REG_POLL_TICKS  = 3'd2;
  localparam logic [2:0] REG_MAX_PULSES  = 3'd3;
  localparam logic [2:0] REG_MAX_POLLS   = 3'd4;

  localparam logic [23:0] INIT_WAIT_RESET   = 24'd2500000;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
  localparam logic [23:0] POLL_TICKS_RESET  = 24'd100000;
  localparam logic [4:0]  MAX_PULSES_RESET  = 5'd20;
  localparam logic [4:0]  MAX_POLLS_RESET   = 5'd20;

  // Completion status codes.
  localparam logic [1:0] ST_OK              = 2'd0;
  localparam logic [1:0] ST_SCL_STUCK       = 2'd1;
  localparam logic [1:0] ST_STRETCH_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_SDA_STUCK       = 2'd3;

  localparam int IN_BITS  = 8;
  localparam int OUT_BITS = 8;

  typedef struct packed {
    logic [23:0] init_wait_ticks;
    logic [15:0] half_period_ticks;
    logic [23:0] stretch_poll_ticks;
    logic [4:0]  max_pulses;
    logic [4:0]  max_stretch_polls;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic       done_res;
    logic       busy_res;
    logic       pullups_on;
    logic       sda_drive_low;
    logic       scl_drive_low;
  } result_t;

endpackage

FILE: rtl/i2cbr_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2cbr_cfg_regs
// APB register file holding the timing and retry limits of the sequencer.
// ----------------------------------------------------------------------------
module i2cbr_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output i2cbr_pkg::cfg_t     cfg
);
  import i2cbr_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_wait_ticks    <= INIT_WAIT_RESET;
      cfg.half_period_ticks  <= HALF_PERIOD_RESET;
      cfg.stretch_poll_ticks <= POLL_TICKS_RESET;
      cfg.max_pulses         <= MAX_PULSES_RESET;
      cfg.max_stretch_polls  <= MAX_POLLS_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_INIT_WAIT:   cfg.init_wait_ticks    <= pwdata[23:0];
        REG_HALF_PERIOD: cfg.half_period_ticks  <= pwdata[15:0];
        REG_POLL_TICKS:  cfg.stretch_poll_ticks <= pwdata[23:0];
        REG_MAX_PULSES:  cfg.max_pulses         <= pwdata[4:0];
        REG_MAX_POLLS:   cfg.max_stretch_polls  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INIT_WAIT:   prdata = {8'd0, cfg.init_wait_ticks};
      REG_HALF_PERIOD: prdata = {16'd0, cfg.half_period_ticks};
      REG_POLL_TICKS:  prdata = {8'd0, cfg.stretch_poll_ticks};
      REG_MAX_PULSES:  prdata = {27'd0, cfg.max_pulses};
      REG_MAX_POLLS:   prdata = {27'd0, cfg.max_stretch_polls};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/i2cbr_seq_core.sv
// ----------------------------------------------------------------------------
// i2cbr_seq_core
// Recovery state machine: one tick per accepted transaction, one result each.
// ----------------------------------------------------------------------------
module i2cbr_seq_core #(
  parameter int TIMER_BITS = i2cbr_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  i2cbr_pkg::cfg_t     cfg,
  input  logic                tick,
  input  logic                start_request,
  input  logic                scl_level,
  input  logic                sda_level,
  output i2cbr_pkg::result_t  result
);
  import i2cbr_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_INIT     = 3'd1;
  localparam logic [2:0] PH_PLOW     = 3'd2;
  localparam logic [2:0] PH_PHIGH    = 3'd3;
  localparam logic [2:0] PH_STRETCH  = 3'd4;
  localparam logic [2:0] PH_STARTLOW = 3'd5;
  localparam logic [2:0] PH_STOPHIGH = 3'd6;

  localparam logic [32:0] TIMER_LIM = (33'd1 << TIMER_BITS) - 33'd1;

  // Saturate to the timer width, and treat a zero load as one tick.
  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [23:0] v);
    logic [32:0] ext;
    ext = {9'd0, v};
    if (ext > TIMER_LIM) ext = TIMER_LIM;
    if (ext == 33'd0) ext = 33'd1;
    return ext[TIMER_BITS-1:0];
  endfunction

  logic [2:0]            phase, phase_next;
  logic [TIMER_BITS-1:0] wait_timer, wait_timer_next;
  logic [4:0]            pulses_left, pulses_left_next;
  logic [4:0]            polls_left, polls_left_next;
  logic [1:0]            last_status, last_status_next;
  logic                  fin, do_check, expire;
  logic [1:0]            fin_status;

  always_comb begin
    phase_next       = phase;
    wait_timer_next  = wait_timer;
    pulses_left_next = pulses_left;
    polls_left_next  = polls_left;
    last_status_next = last_status;
    fin              = 1'b0;
    fin_status       = ST_OK;
    do_check         = 1'b0;
    expire           = (wait_timer <= TIMER_BITS'(1));

    if (phase == PH_IDLE) begin
      if (start_request) begin
        phase_next      = PH_INIT;
        wait_timer_next = timer_load(cfg.init_wait_ticks);
      end
    end else if (!expire) begin
      wait_timer_next = wait_timer - TIMER_BITS'(1);
    end else begin
      unique case (phase)
        PH_INIT: begin
          if (!scl_level) begin
            fin        = 1'b1;
            fin_status = ST_SCL_STUCK;
          end else begin
            pulses_left_next = cfg.max_pulses;
            do_check         = 1'b1;
          end
        end
        PH_PLOW: begin
          phase_next      = PH_PHIGH;
          wait_timer_next = timer_load({8'd0, cfg.half_period_ticks});
        end
        PH_PHIGH: begin
          if (scl_level) begin
            do_check = 1'b1;
          end else begin
            polls_left_next = cfg.max_stretch_polls;
            if (cfg.max_stretch_polls == 5'd0) begin
              fin        = 1'b1;
              fin_status = ST_STRETCH_TIMEOUT;
            end else begin
              phase_next      = PH_STRETCH;
              wait_timer_next = timer_load(cfg.stretch_poll_ticks);
            end
          end
        end
        PH_STRETCH: begin
          polls_left_next = polls_left - 5'd1;
          if (scl_level) begin
            do_check = 1'b1;
          end else if (polls_left_next == 5'd0) begin
            fin        = 1'b1;
            fin_status = ST_STRETCH_TIMEOUT;
          end else begin
            wait_timer_next = timer_load(cfg.stretch_poll_ticks);
          end
        end
        PH_STARTLOW: begin
          phase_next      = PH_STOPHIGH;
          wait_timer_next = timer_load({8'd0, cfg.half_period_ticks});
        end
        PH_STOPHIGH: begin
          fin        = 1'b1;
          fin_status = ST_OK;
        end
        default: begin
          phase_next      = PH_IDLE;
          wait_timer_next = '0;
        end
      endcase
    end

    // SDA decision shared by the initial check and the end of each pulse.
    if (do_check) begin
      if (!sda_level) begin
        if (pulses_left_next == 5'd0) begin
          fin        = 1'b1;
          fin_status = ST_SDA_STUCK;
        end else begin
          pulses_left_next = pulses_left_next - 5'd1;
          phase_next       = PH_PLOW;
          wait_timer_next  = timer_load({8'd0, cfg.half_period_ticks});
        end
      end else begin
        phase_next      = PH_STARTLOW;
        wait_timer_next = timer_load({8'd0, cfg.half_period_ticks});
      end
    end

    if (fin) begin
      phase_next       = PH_IDLE;
      wait_timer_next  = '0;
      last_status_next = fin_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      wait_timer  <= '0;
      pulses_left <= 5'd0;
      polls_left  <= 5'd0;
      last_status <= ST_OK;
    end else if (tick) begin
      phase       <= phase_next;
      wait_timer  <= wait_timer_next;
      pulses_left <= pulses_left_next;
      polls_left  <= polls_left_next;
      last_status <= last_status_next;
    end
  end

  always_comb begin
    result.scl_drive_low = (phase_next == PH_PLOW);
    result.sda_drive_low = (phase_next == PH_STARTLOW);
    result.pullups_on    = (phase_next != PH_IDLE);
    result.busy_res      = (phase_next != PH_IDLE);
    result.done_res      = fin;
    result.status        = last_status_next;
  end

endmodule

FILE: rtl/i2cbr_out_skid.sv
// ----------------------------------------------------------------------------
// i2cbr_out_skid
// Output register with one skid entry, so input ready does not wait on the
// downstream ready.
// ----------------------------------------------------------------------------
module i2cbr_out_skid #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && !skid_valid) begin
      skid_data <= in_data;
    end
  end

endmodule

FILE: rtl/i2c_bus_recovery_sequencer_top.sv
// ----------------------------------------------------------------------------
// i2c_bus_recovery_sequencer_top
// I2C bus-clear recovery sequencer with stream channels and an APB port.
// ----------------------------------------------------------------------------
// Each slave-side transaction is one timing tick carrying a start request and
// the sampled SCL and SDA levels. Every tick yields exactly one master-side
// transaction with the line drives, pull-up enable, busy, done and status as
// they stand after that tick.
// Throughput is one tick per clock cycle while the receiver keeps up; the state
// machine updates in the cycle a tick is accepted and the result is presented
// from the output register.
// An output register plus one skid entry separate the channels: while the
// receiver stalls, one further tick is still taken, then s_axis_tready drops
// until the receiver accepts the waiting result. No result is dropped or
// repeated.
// Reset (rst, synchronous) returns the sequencer to idle with status ok and
// loads the register defaults; the output buffer is emptied.
// Registers are at byte addresses 0, 4, 8, 12 and 16: init wait ticks, half
// period ticks, stretch poll ticks, max pulses and max stretch polls. Write
// them only while no tick is in flight.
// ----------------------------------------------------------------------------
module i2c_bus_recovery_sequencer_top #(
  parameter int TIMER_BITS = i2cbr_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] start_request, [1] scl_level, [2] sda_level, [7:3] zero
  input  logic [i2cbr_pkg::IN_BITS-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] scl_drive_low, [1] sda_drive_low, [2] pullups_on, [3] busy_res,
  // [4] done_res, [6:5] status, [7] zero
  output logic [i2cbr_pkg::OUT_BITS-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import i2cbr_pkg::*;

  cfg_t          cfg;
  result_t       result;
  logic          tick;
  logic [OUT_BITS-1:0] res_data;

  assign tick     = s_axis_tvalid & s_axis_tready;
  assign res_data = {1'b0, result};

  i2cbr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cbr_seq_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .tick          (tick),
    .start_request (s_axis_tdata[0]),
    .scl_level     (s_axis_tdata[1]),
    .sda_level     (s_axis_tdata[2]),
    .result        (result)
  );

  i2cbr_out_skid #(
    .W (OUT_BITS)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick),
    .in_ready  (s_axis_tready),
    .in_data   (res_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // A finishing tick always shows the sequencer back at idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3] && !m_axis_tdata[2])
    else $error("done with busy or pull-ups still set");

  // The sequencer never drives both lines low at once.
  a_one_line_low: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("SCL and SDA driven low together");

  // Input back-pressure only arises while a result is waiting.
  a_ready_low_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // Any line drive implies an active sequence.
  a_drive_implies_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[1]) |-> m_axis_tdata[3])
    else $error("line driven while idle");
`endif

endmodule
